/* hdl/xrbg_pkg.sv */
// Shared types, constants and helpers for the xorshift range and bag generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package xrbg_pkg;

    localparam int          WORD_W       = 32;
    localparam int          HALF_W       = WORD_W - 1;
    localparam int          PIECE_W      = 3;
    localparam int          BAG_SIZE_DEF = 7;
    localparam int          CNT_W        = 5;
    localparam logic [31:0] SEED_DEFAULT = 32'hCAFEBABE;
    localparam int          SHIFT_A      = 13;
    localparam int          SHIFT_B      = 17;
    localparam int          SHIFT_C      = 5;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_RAW   = 2'd0;
    localparam logic [1:0] FUNC_RANGE = 2'd1;
    localparam logic [1:0] FUNC_BAG   = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        raw_word;
        logic signed [31:0] ranged_value;
        logic [2:0]         piece;
    } out_item_t;

    // Source of the data written into the bag memory.
    typedef enum logic [1:0] {
        WR_INDEX,
        WR_RDATA,
        WR_HELD
    } wsel_t;

    typedef struct packed {
        logic       take_in;
        logic       advance;
        logic       start_draw;
        logic       bag_draw;
        logic [2:0] bag_k;
        logic       div_step;
        logic       ram_re;
        logic       ram_we;
        wsel_t      wsel;
        logic [2:0] addr;
        logic       hold_k;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       div_last;
        logic [2:0] slot_j;
    } stat_t;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

/* hdl/xrbg_ram.sv */
// Generic single-port-write, registered-read memory.
// Stand-alone; holds the shuffled bag slots.
module xrbg_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 7
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hdl/xrbg_datapath.sv */
// Datapath: generator word, bit-serial remainder unit, bag memory and result register.
// Depends on xrbg_pkg and xrbg_ram; driven by xrbg_ctrl through cmd_t.
module xrbg_datapath #(
    parameter int BAG_SIZE = xrbg_pkg::BAG_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xrbg_pkg::in_item_t  in_data,
    input  logic                seed_we,
    input  logic [31:0]         seed_wdata,
    input  xrbg_pkg::cmd_t      cmd,
    output xrbg_pkg::stat_t     stat,
    output xrbg_pkg::out_item_t out_data
);
    import xrbg_pkg::*;

    localparam int SLOT_W = $clog2(BAG_SIZE);

    logic [31:0]        gen_reg;
    logic [31:0]        gen_next;
    logic [1:0]         func_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [32:0]        span_reg;
    logic [31:0]        rem_reg;
    logic [HALF_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]  held_reg;
    out_item_t          out_reg;

    logic [32:0]        diff;
    logic [32:0]        ext_span;
    logic [32:0]        bag_span;
    logic [32:0]        trial;
    logic [SLOT_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]  ram_rdata;

    assign gen_next = xorshift(gen_reg);

    // The span is formed one bit wider than the bounds so it cannot wrap.
    assign diff     = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
    assign ext_span = diff[32] ? 33'd1 : diff + 33'd1;
    assign bag_span = 33'(cmd.bag_k) + 33'd1;
    assign trial    = {rem_reg, dvd_reg[HALF_W-1]};

    always_comb
    begin
        case (cmd.wsel)
            WR_INDEX: ram_wdata = cmd.addr[SLOT_W-1:0];
            WR_RDATA: ram_wdata = ram_rdata;
            WR_HELD:  ram_wdata = held_reg;
            default:  ram_wdata = '0;
        endcase
    end

    xrbg_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (BAG_SIZE)
    ) u_bag_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (cmd.addr[SLOT_W-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.ram_re),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= SEED_DEFAULT;
        end
        else if (seed_we)
        begin
            gen_reg <= (seed_wdata == 32'd0) ? SEED_DEFAULT : seed_wdata;
        end
        else if (cmd.advance || cmd.start_draw)
        begin
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            func_reg <= in_data.func;
            lo_reg   <= in_data.lo;
            hi_reg   <= in_data.hi;
        end
        if (cmd.start_draw)
        begin
            span_reg <= cmd.bag_draw ? bag_span : ext_span;
            dvd_reg  <= gen_next[WORD_W-1:1];
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(HALF_W);
        end
        else if (cmd.div_step)
        begin
            // One restoring step per cycle, most significant dividend bit first.
            if (trial >= span_reg)
            begin
                rem_reg <= 32'(trial - span_reg);
            end
            else
            begin
                rem_reg <= trial[31:0];
            end
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.hold_k)
        begin
            held_reg <= ram_rdata;
        end
        if (cmd.load_out)
        begin
            out_reg.raw_word     <= gen_reg;
            out_reg.ranged_value <= (func_reg == FUNC_RANGE) ? lo_reg + signed'(rem_reg) : '0;
            out_reg.piece        <= (func_reg == FUNC_BAG) ? PIECE_W'(ram_rdata) : '0;
        end
    end

    assign stat.func     = func_reg;
    assign stat.div_last = (cnt_reg == CNT_W'(1));
    assign stat.slot_j   = PIECE_W'(rem_reg[SLOT_W-1:0]);
    assign out_data      = out_reg;

endmodule

/* hdl/xrbg_ctrl.sv */
// Controller: sequences each request, the bag refill and shuffle, and the result beat.
// Depends on xrbg_pkg; drives xrbg_datapath through cmd_t.
module xrbg_ctrl #(
    parameter int BAG_SIZE = xrbg_pkg::BAG_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  xrbg_pkg::stat_t stat,
    output xrbg_pkg::cmd_t  cmd
);
    import xrbg_pkg::*;

    localparam int               IDX_W    = $clog2(BAG_SIZE);
    localparam int               POS_W    = $clog2(BAG_SIZE + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BAG_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADV,
        S_FILL,
        S_DRAW,
        S_DIV,
        S_RDK,
        S_RDJ,
        S_WRK,
        S_WRJ,
        S_PICK,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [POS_W-1:0] pos_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             bag_mode_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.wsel       = WR_INDEX;
        cmd.bag_draw   = bag_mode_reg;
        cmd.bag_k      = PIECE_W'(idx_reg);
        cmd.addr       = PIECE_W'(idx_reg);
        unique case (state_reg)
            S_IDLE:   cmd.take_in = in_valid;
            S_ADV:    cmd.advance = 1'b1;
            S_FILL:   cmd.ram_we = 1'b1;
            S_DRAW:   cmd.start_draw = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_RDK:    cmd.ram_re = 1'b1;
            S_RDJ:
            begin
                cmd.ram_re = 1'b1;
                cmd.addr   = stat.slot_j;
                cmd.hold_k = 1'b1;
            end
            S_WRK:
            begin
                cmd.ram_we = 1'b1;
                cmd.wsel   = WR_RDATA;
            end
            S_WRJ:
            begin
                cmd.ram_we = 1'b1;
                cmd.wsel   = WR_HELD;
                cmd.addr   = stat.slot_j;
            end
            S_PICK:
            begin
                cmd.ram_re = 1'b1;
                cmd.addr   = PIECE_W'(pos_reg);
            end
            S_FINISH: cmd.load_out = out_free;
            default:  cmd.take_in = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            idx_reg       <= '0;
            bag_mode_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In the finish state a taken beat is replaced by the new one below.
            if (out_ready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    case (stat.func)
                        FUNC_RAW:   state_reg <= S_ADV;
                        FUNC_RANGE:
                        begin
                            bag_mode_reg <= 1'b0;
                            state_reg    <= S_DRAW;
                        end
                        FUNC_BAG:
                        begin
                            if (pos_reg == '0 || pos_reg >= POS_W'(BAG_SIZE))
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_FILL;
                            end
                            else
                            begin
                                state_reg <= S_PICK;
                            end
                        end
                        default:    state_reg <= S_FINISH;
                    endcase
                end
                S_ADV:    state_reg <= S_FINISH;
                S_FILL:
                begin
                    // Slots are loaded with their own index, then shuffled downward.
                    if (idx_reg == LAST_IDX)
                    begin
                        bag_mode_reg <= 1'b1;
                        state_reg    <= S_DRAW;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_DRAW:   state_reg <= S_DIV;
                S_DIV:
                begin
                    if (stat.div_last)
                    begin
                        state_reg <= bag_mode_reg ? S_RDK : S_FINISH;
                    end
                end
                S_RDK:    state_reg <= S_RDJ;
                S_RDJ:    state_reg <= S_WRK;
                S_WRK:    state_reg <= S_WRJ;
                S_WRJ:
                begin
                    if (idx_reg == IDX_W'(1))
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - IDX_W'(1);
                        state_reg <= S_DRAW;
                    end
                end
                S_PICK:
                begin
                    pos_reg   <= pos_reg + POS_W'(1);
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/xorshift_range_and_bag_generator.sv */
// Xorshift32 generator (shifts 13, 17, 5) serving raw words, ranged draws and
// pieces from a shuffled bag of BAG_SIZE. One request is worked on at a time;
// a finished result beat waits in an output register while the next request
// is taken. A ranged draw goes through the bit-serial remainder unit, which
// retires one of the 31 dividend bits per cycle. A bag piece that needs a
// refill first fills the bag, writing one slot per cycle, and then shuffles
// it: each shuffle step is a draw through the same remainder unit plus a swap
// (read k, read j, write k, write j) through the single port of the bag memory.
// A seed write reloads the generator word at once; zero loads 0xCAFEBABE.
// Depends on xrbg_pkg, xrbg_ctrl and xrbg_datapath.
module xorshift_range_and_bag_generator #(
    parameter int BAG_SIZE = xrbg_pkg::BAG_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_we,
    input  logic [31:0]         seed_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  xrbg_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output xrbg_pkg::out_item_t out_data
);
    import xrbg_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    xrbg_ctrl #(
        .BAG_SIZE (BAG_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    xrbg_datapath #(
        .BAG_SIZE (BAG_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    // Pieces always come from a shuffled bag, so they stay below the bag size.
    a_piece_in_bag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.piece} < 4'(BAG_SIZE)))
        else $error("piece outside the bag");

    // A beat carries a piece or a ranged value, never both.
    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.piece != 3'd0) |-> (out_data.ranged_value == 32'sd0))
        else $error("piece and ranged value both set");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for xorshift_range_and_bag_generator: a directed table,
// then random requests under several seeds and flow-control patterns.
// Depends on xrbg_pkg and the generator RTL in hdl/.
`timescale 1ns / 100ps

module tb;

    import xrbg_pkg::*;

    localparam int BAG_N          = BAG_SIZE_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 100;
    localparam int DIR_ROWS       = 24;

    localparam logic signed [31:0] S_MIN = 32'sh80000000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S_M1  = -32'sd1;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      seed_we    = 1'b0;
    logic      [31:0] seed_wdata = '0;
    logic      in_valid   = 1'b0;
    logic      in_ready;
    in_item_t  in_data    = '0;
    logic      out_valid;
    logic      out_ready  = 1'b0;
    out_item_t out_data;

    // Expected result beats, oldest first.
    out_item_t results_due[$];
    int        errors = 0;

    // Own copy of the generator, bag and position.
    logic [31:0] model_word = SEED_DEFAULT;
    logic [2:0]  model_bag [0:7];
    int          model_pos = 0;

    // Flow-control knobs, set by the main sequence.
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    dir_row_t dir_rows [0:DIR_ROWS-1];

    always #1 clk = ~clk;

    xorshift_range_and_bag_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    function automatic logic [31:0] next_word();
        logic [31:0] x;
        x = model_word;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        model_word = x;
        return x;
    endfunction

    // Span is formed in 64 bits so that the full signed range does not wrap.
    function automatic longint draw_between(longint lo, longint hi);
        longint span;
        longint half;
        span = hi - lo + 1;
        half = longint'(next_word() >> 1);
        if (span < 1)
            span = 1;
        return lo + (half % span);
    endfunction

    function automatic void shuffle_bag();
        int j;
        logic [2:0] t;
        for (int k = 0; k < BAG_N; k++)
            model_bag[k] = 3'(k);
        for (int k = BAG_N - 1; k >= 1; k--)
        begin
            j = int'(draw_between(0, k)) & 7;
            t = model_bag[k];
            model_bag[k] = model_bag[j];
            model_bag[j] = t;
        end
        model_pos = 0;
    endfunction

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        longint lo_w;
        longint hi_w;
        r = '0;
        lo_w = $signed(it.lo);
        hi_w = $signed(it.hi);
        case (it.func)
            FUNC_RAW:
                void'(next_word());
            FUNC_RANGE:
                r.ranged_value = 32'(draw_between(lo_w, hi_w));
            FUNC_BAG:
            begin
                if (model_pos == 0 || model_pos >= BAG_N)
                    shuffle_bag();
                r.piece = model_bag[model_pos & 7];
                model_pos++;
            end
            default:
                ;
        endcase
        r.raw_word = model_word;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return S_MIN;
            1: return S_MAX;
            2: return S_M1;
            3: return 32'sd0;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t it;
        int pick;
        it.lo = $urandom;
        it.hi = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.func = FUNC_RAW;
        else if (pick < 55)
            it.func = FUNC_RANGE;
        else if (pick < 95)
            it.func = FUNC_BAG;
        else
            it.func = FUNC_NONE;
        if (it.func == FUNC_RANGE)
        begin
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    // Narrow spans around zero, now and then empty.
                    it.lo = 32'($urandom_range(0, 2000)) - 32'd1000;
                    it.hi = it.lo + 32'($urandom_range(0, 40)) - 32'd4;
                end
                2:
                begin
                    it.lo = pick_edge();
                    it.hi = pick_edge();
                end
                default:
                    it.hi = it.lo + 32'($urandom_range(0, 65535));
            endcase
        end
        return it;
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] f, logic signed [31:0] lo,
                                        logic signed [31:0] hi);
        dir_row_t d;
        d.req.func = f;
        d.req.lo = lo;
        d.req.hi = hi;
        d.typed = 1'b0;
        d.want = '0;
        return d;
    endfunction

    // Offers one request, after an optional idle gap, and waits until it is taken.
    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        int gap;
        out_item_t r;
        gap = 0;
        while ($urandom_range(0, 99) < snd_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_result(it);
        results_due.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] v);
        seed_we <= 1'b1;
        seed_wdata <= v;
        @(posedge clk);
        model_word = (v == 32'd0) ? SEED_DEFAULT : v;
        seed_we <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random stalls plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (holds_done < holds_asked)
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_data.raw_word !== want.raw_word)
                begin
                    $display("%0t: raw_word expected %h actual %h",
                             $time, want.raw_word, out_data.raw_word);
                    errors++;
                end
                if (out_data.ranged_value !== want.ranged_value)
                begin
                    $display("%0t: ranged_value expected %0d actual %0d",
                             $time, want.ranged_value, out_data.ranged_value);
                    errors++;
                end
                if (out_data.piece !== want.piece)
                begin
                    $display("%0t: piece expected %0d actual %0d",
                             $time, want.piece, out_data.piece);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] seed_val;
        for (int k = 0; k < 8; k++)
            model_bag[k] = 3'd0;

        // The unused code right after reset shows the reset word untouched.
        dir_rows[0]  = mk_row(FUNC_NONE, 32'sd0, 32'sd0);
        dir_rows[0].typed = 1'b1;
        dir_rows[0].want = '{SEED_DEFAULT, 32'sd0, 3'd0};
        dir_rows[1]  = mk_row(FUNC_NONE, S_M1, S_M1);
        dir_rows[1].typed = 1'b1;
        dir_rows[1].want = '{SEED_DEFAULT, 32'sd0, 3'd0};
        dir_rows[2]  = mk_row(FUNC_RAW, 32'sd0, 32'sd0);
        dir_rows[3]  = mk_row(FUNC_RAW, S_MAX, S_MIN);
        dir_rows[4]  = mk_row(FUNC_RANGE, 32'sd0, 32'sd0);
        dir_rows[5]  = mk_row(FUNC_RANGE, S_MIN, S_MAX);
        dir_rows[6]  = mk_row(FUNC_RANGE, S_MAX, S_MIN);
        dir_rows[7]  = mk_row(FUNC_RANGE, S_MAX, S_MAX);
        dir_rows[8]  = mk_row(FUNC_RANGE, S_MIN, S_MIN);
        dir_rows[9]  = mk_row(FUNC_RANGE, S_MIN, S_M1);
        dir_rows[10] = mk_row(FUNC_RANGE, 32'sd0, S_MAX);
        dir_rows[11] = mk_row(FUNC_RANGE, S_M1, 32'sd0);
        dir_rows[12] = mk_row(FUNC_RANGE, 32'sd0, S_M1);
        dir_rows[13] = mk_row(FUNC_RANGE, -32'sd5, 32'sd5);
        // Eight bag pieces: a refill, six plain reads, then a second refill.
        for (int k = 14; k < 22; k++)
            dir_rows[k] = mk_row(FUNC_BAG, S_M1, S_MIN);
        dir_rows[22] = mk_row(FUNC_NONE, 32'sd0, 32'sd0);
        dir_rows[23] = mk_row(FUNC_RANGE, 32'sd1, 32'sd1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        for (int p = 1; p <= 5; p++)
        begin
            wait_drained();
            case (p)
                1: begin seed_val = 32'd0;        snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                2: begin seed_val = 32'hFFFFFFFF; snd_idle_pct = 70; rcv_stall_pct = 0;  end
                3: begin seed_val = $urandom;     snd_idle_pct = 0;  rcv_stall_pct = 70; end
                4: begin seed_val = 32'd1;        snd_idle_pct = 21; rcv_stall_pct = 21; end
                default:
                begin
                    seed_val = 32'h80000000;
                    snd_idle_pct = 0;
                    rcv_stall_pct = 0;
                end
            endcase
            write_seed(seed_val);
            // The last phase backs up the block behind a long result hold-off.
            if (p == 5)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_item(random_request(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (results_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
